### rtl/eatrm_pkg.sv
// Shared constants, types and helpers for the Euler-angle to rotation-matrix block.
`timescale 1ns / 1ps
`default_nettype none
package eatrm_pkg;

  localparam int AngleBits   = 16;
  localparam int ElementBits = 16;
  localparam int Frac        = 30;
  localparam int CordicSteps = 30;
  localparam int WW          = 36;  // CORDIC datapath width, Q5.30

  localparam logic signed [WW-1:0] PiQ30     = 36'sd3373259426;
  localparam logic signed [WW-1:0] HalfPiQ30 = 36'sd1686629713;
  localparam logic signed [WW-1:0] TwoPiQ30  = 36'sd6746518852;
  localparam logic signed [WW-1:0] GainQ30   = 36'sd652032874;
  localparam logic signed [WW-1:0] OneQ30    = 36'sd1073741824;

  typedef enum logic [1:0] {
    CONV_XYZ = 2'd0,
    CONV_ZYZ = 2'd1,
    CONV_ZYX = 2'd2,
    CONV_RSV = 2'd3
  } conv_e;

  typedef logic signed [WW-1:0] q30_t;

  typedef struct packed {
    q30_t s;
    q30_t c;
  } sc_t;

  function automatic q30_t atan_q30(input logic [4:0] i);
    logic [31:0] v;
    begin
      case (i)
        5'd0:  v = 32'h3243F6A8;
        5'd1:  v = 32'h1DAC6705;
        5'd2:  v = 32'h0FADBAFC;
        5'd3:  v = 32'h07F56EA6;
        5'd4:  v = 32'h03FEAB76;
        5'd5:  v = 32'h01FFD55B;
        5'd6:  v = 32'h00FFFAAA;
        5'd7:  v = 32'h007FFF55;
        5'd8:  v = 32'h003FFFEA;
        5'd9:  v = 32'h001FFFFD;
        5'd10: v = 32'h000FFFFF;
        5'd11: v = 32'h0007FFFF;
        5'd12: v = 32'h0003FFFF;
        5'd13: v = 32'h0001FFFF;
        5'd14: v = 32'h0000FFFF;
        5'd15: v = 32'h00007FFF;
        5'd16: v = 32'h00003FFF;
        5'd17: v = 32'h00001FFF;
        5'd18: v = 32'h00000FFF;
        5'd19: v = 32'h000007FF;
        5'd20: v = 32'h000003FF;
        5'd21: v = 32'h000001FF;
        5'd22: v = 32'h000000FF;
        5'd23: v = 32'h0000007F;
        5'd24: v = 32'h0000003F;
        5'd25: v = 32'h0000001F;
        5'd26: v = 32'h0000000F;
        5'd27: v = 32'h00000008;
        5'd28: v = 32'h00000004;
        5'd29: v = 32'h00000002;
        default: v = 32'h0;
      endcase
      atan_q30 = q30_t'(v);
    end
  endfunction

endpackage
`default_nettype wire

### rtl/eatrm_cordic.sv
// One CORDIC lane: pipelined sine and cosine of a Q2.13 angle in Q30.
`timescale 1ns / 1ps
`default_nettype none
module eatrm_cordic (
  input  wire logic                                      clk_i,
  input  wire logic                                      en_i,
  input  wire logic signed [eatrm_pkg::AngleBits-1:0]    angle_i,
  output eatrm_pkg::sc_t                                 sc_o
);
  localparam int N  = eatrm_pkg::CordicSteps;
  localparam int WW = eatrm_pkg::WW;

  eatrm_pkg::q30_t x_q [N+1];
  eatrm_pkg::q30_t y_q [N+1];
  eatrm_pkg::q30_t z_q [N+1];
  logic            neg_q [N+1];

  eatrm_pkg::q30_t z0, z1;
  logic            neg0;

  always_comb begin
    z0 = eatrm_pkg::q30_t'(angle_i) <<< (eatrm_pkg::Frac - (eatrm_pkg::AngleBits - 3));
    if (z0 > eatrm_pkg::PiQ30)       z0 = z0 - eatrm_pkg::TwoPiQ30;
    else if (z0 < -eatrm_pkg::PiQ30) z0 = z0 + eatrm_pkg::TwoPiQ30;
    neg0 = 1'b0;
    z1 = z0;
    if (z0 > eatrm_pkg::HalfPiQ30) begin
      z1 = z0 - eatrm_pkg::PiQ30; neg0 = 1'b1;
    end else if (z0 < -eatrm_pkg::HalfPiQ30) begin
      z1 = z0 + eatrm_pkg::PiQ30; neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]   <= eatrm_pkg::GainQ30;
      y_q[0]   <= '0;
      z_q[0]   <= z1;
      neg_q[0] <= neg0;
      for (int i = 0; i < N; i++) begin
        neg_q[i+1] <= neg_q[i];
        if (!z_q[i][WW-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - eatrm_pkg::atan_q30(5'(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + eatrm_pkg::atan_q30(5'(i));
        end
      end
    end
  end

  always_comb begin
    sc_o.s = neg_q[N] ? -y_q[N] : y_q[N];
    sc_o.c = neg_q[N] ? -x_q[N] : x_q[N];
  end
endmodule
`default_nettype wire

### rtl/eatrm_merge.sv
// Merge stage: builds the three axis matrices and multiplies them out.
`timescale 1ns / 1ps
`default_nettype none
module eatrm_merge (
  input  wire logic                   clk_i,
  input  wire logic                   en_i,
  input  wire logic [1:0]             conv_i,
  input  wire eatrm_pkg::sc_t         sc_a_i,
  input  wire eatrm_pkg::sc_t         sc_b_i,
  input  wire eatrm_pkg::sc_t         sc_c_i,
  output logic [9*eatrm_pkg::ElementBits-1:0] elem_o
);
  localparam int WW = eatrm_pkg::WW;
  localparam int EB = eatrm_pkg::ElementBits;
  localparam int OW = 32;  // matrix entries stay within +-2.0 in Q30
  localparam int PW = 2 * OW;
  localparam int SH = eatrm_pkg::Frac - (EB - 2);

  typedef eatrm_pkg::q30_t mat_t [3][3];

  function automatic mat_t rot(input logic [1:0] axis, input eatrm_pkg::sc_t v);
    mat_t m;
    int p, q;
    begin
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          m[i][j] = (i == j) ? eatrm_pkg::OneQ30 : '0;
      if (axis == 2'd0) begin p = 1; q = 2; end
      else if (axis == 2'd1) begin p = 2; q = 0; end
      else begin p = 0; q = 1; end
      m[p][p] = v.c; m[q][q] = v.c; m[p][q] = -v.s; m[q][p] = v.s;
      rot = m;
    end
  endfunction

  mat_t m1, m2, m3;
  mat_t m1_q, m2_q, m3_q, m3_q2, m3_q3, t_q;
  logic signed [PW-1:0] p1_q [3][3][3];
  logic signed [PW-1:0] p2_q [3][3][3];

  always_comb begin
    unique case (conv_i)
      eatrm_pkg::CONV_ZYZ: begin
        m1 = rot(2'd2, sc_a_i); m2 = rot(2'd1, sc_b_i); m3 = rot(2'd2, sc_c_i);
      end
      eatrm_pkg::CONV_ZYX: begin
        m1 = rot(2'd2, sc_c_i); m2 = rot(2'd1, sc_b_i); m3 = rot(2'd0, sc_a_i);
      end
      default: begin
        m1 = rot(2'd0, sc_a_i); m2 = rot(2'd1, sc_b_i); m3 = rot(2'd2, sc_c_i);
      end
    endcase
  end

  function automatic logic signed [PW-1:0] rnd(input logic signed [PW-1:0] v,
                                               input int s);
    rnd = (v + (PW'(1) <<< (s - 1))) >>> s;
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_q <= m1; m2_q <= m2; m3_q <= m3;
      m3_q2 <= m3_q;
      m3_q3 <= m3_q2;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          for (int k = 0; k < 3; k++) begin
            p1_q[i][j][k] <= PW'($signed(m1_q[i][k][OW-1:0]) *
                                 $signed(m2_q[k][j][OW-1:0]));
            p2_q[i][j][k] <= PW'($signed(t_q[i][k][OW-1:0]) *
                                 $signed(m3_q3[k][j][OW-1:0]));
          end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i)
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          t_q[i][j] <= WW'(rnd(p1_q[i][j][0] + p1_q[i][j][1] + p1_q[i][j][2],
                               eatrm_pkg::Frac));
  end

  // m3 must line up with t: t passes through p1_q and t_q after m1_q, so m3 takes three stages

  always_ff @(posedge clk_i) begin
    logic signed [PW-1:0] r, e;
    if (en_i)
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          r = rnd(p2_q[i][j][0] + p2_q[i][j][1] + p2_q[i][j][2], eatrm_pkg::Frac);
          e = rnd(r, SH);
          if (e > (PW'(1) <<< (EB - 2)))        e = PW'(1) <<< (EB - 2);
          else if (e < -(PW'(1) <<< (EB - 2)))  e = -(PW'(1) <<< (EB - 2));
          elem_o[(i*3+j)*EB +: EB] <= e[EB-1:0];
        end
  end
endmodule
`default_nettype wire

### rtl/euler_angles_to_rotation_matrix.sv
// Top level: three CORDIC lanes, matrix merge stage, output handshake.
//  channel | dir | content
//  s_axis  | in  | tdata = angle_a, angle_b, angle_c (16b each)
//  m_axis  | out | tdata = out_r0c0 .. out_r2c2 (16b each, row-major)
//  cfg     | in  | cfg_we_i/cfg_wdata_i = angle_convention
// One word per cycle while m_axis is not stalled; 31 CORDIC stages, 5 merge stages.
// The whole pipeline advances only when the output register can take a word,
// so a stall on m_axis holds every stage. Reset clears valid bits and convention.
`timescale 1ns / 1ps
`default_nettype none
module euler_angles_to_rotation_matrix (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cfg_we_i,
  input  wire logic [1:0]    cfg_wdata_i,
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [47:0]   s_axis_tdata,   // angle_a, angle_b, angle_c
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [143:0]       m_axis_tdata    // out_r0c0 .. out_r2c2
);
  localparam int AB  = eatrm_pkg::AngleBits;
  localparam int LAT = eatrm_pkg::CordicSteps + 1 + 5;

  logic [1:0]     conv_q;
  logic [LAT-1:0] vld_q;
  logic           en;
  eatrm_pkg::sc_t sc_a, sc_b, sc_c;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conv_q <= eatrm_pkg::CONV_XYZ;
      vld_q  <= '0;
    end else begin
      if (cfg_we_i) conv_q <= cfg_wdata_i;
      if (en) vld_q <= {vld_q[LAT-2:0], s_axis_tvalid};
    end
  end

  eatrm_cordic u_lane_a (.clk_i, .en_i(en), .angle_i(s_axis_tdata[0 +: AB]), .sc_o(sc_a));
  eatrm_cordic u_lane_b (.clk_i, .en_i(en), .angle_i(s_axis_tdata[AB +: AB]), .sc_o(sc_b));
  eatrm_cordic u_lane_c (.clk_i, .en_i(en), .angle_i(s_axis_tdata[2*AB +: AB]),
                         .sc_o(sc_c));

  eatrm_merge u_merge (
    .clk_i, .en_i(en), .conv_i(conv_q),
    .sc_a_i(sc_a), .sc_b_i(sc_b), .sc_c_i(sc_c),
    .elem_o(m_axis_tdata)
  );
endmodule
`default_nettype wire

### sim/euler_angles_to_rotation_matrix_test.sv
// Self-checking testbench for the Euler-angle to rotation-matrix converter.
`timescale 1ns / 1ps
module euler_angles_to_rotation_matrix_test;

  typedef logic signed [63:0] s64_t;
  typedef s64_t mat_t [3][3];

  localparam s64_t PiQ   = 64'sd3373259426;
  localparam s64_t HPiQ  = 64'sd1686629713;
  localparam s64_t TwoPi = 64'sd6746518852;
  localparam s64_t Gain  = 64'sd652032874;
  localparam s64_t OneQ  = 64'sd1073741824;

  class matrix_board;
    logic [143:0] pending[$];
    int errors;
    eatrm_pkg::conv_e conv;

    function new();
      errors = 0;
      conv = eatrm_pkg::CONV_XYZ;
    endfunction

    function automatic s64_t rnd(s64_t v, int s);
      return (v + (s64_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic void sincos(s64_t z, output s64_t sn, output s64_t cs);
      s64_t x, y, t, at;
      bit flip;
      x = Gain; y = 0; flip = 0;
      if (z > PiQ) z -= TwoPi;
      else if (z < -PiQ) z += TwoPi;
      if (z > HPiQ) begin z -= PiQ; flip = 1; end
      else if (z < -HPiQ) begin z += PiQ; flip = 1; end
      for (int i = 0; i < 30; i++) begin
        at = s64_t'(eatrm_pkg::atan_q30(5'(i)));
        if (z >= 0) begin
          t = x - (y >>> i); y = y + (x >>> i); z -= at;
        end else begin
          t = x + (y >>> i); y = y - (x >>> i); z += at;
        end
        x = t;
      end
      sn = flip ? -y : y;
      cs = flip ? -x : x;
    endfunction

    function automatic mat_t axis_rot(int ax, logic signed [15:0] ang);
      mat_t m;
      s64_t sn, cs;
      int p, q;
      sincos(s64_t'(ang) <<< 17, sn, cs);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) m[i][j] = (i == j) ? OneQ : 0;
      p = (ax == 0) ? 1 : (ax == 1) ? 2 : 0;
      q = (ax == 0) ? 2 : (ax == 1) ? 0 : 1;
      m[p][p] = cs; m[q][q] = cs; m[p][q] = -sn; m[q][p] = sn;
      return m;
    endfunction

    function automatic mat_t mul(mat_t a, mat_t b);
      mat_t r;
      s64_t acc;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          acc = 0;
          for (int k = 0; k < 3; k++) acc += a[i][k] * b[k][j];
          r[i][j] = rnd(acc, 30);
        end
      return r;
    endfunction

    function void note_angles(logic [47:0] w);
      mat_t m1, m2, m3, r;
      logic [143:0] e;
      s64_t v;
      logic signed [15:0] a, b, c;
      a = w[15:0]; b = w[31:16]; c = w[47:32];
      m2 = axis_rot(1, b);
      if (conv == eatrm_pkg::CONV_ZYZ) begin
        m1 = axis_rot(2, a); m3 = axis_rot(2, c);
      end else if (conv == eatrm_pkg::CONV_ZYX) begin
        m1 = axis_rot(2, c); m3 = axis_rot(0, a);
      end else begin
        m1 = axis_rot(0, a); m3 = axis_rot(2, c);
      end
      r = mul(mul(m1, m2), m3);
      for (int i = 0; i < 9; i++) begin
        v = rnd(r[i / 3][i % 3], 16);
        if (v > 16384) v = 16384;
        if (v < -16384) v = -16384;
        e[i*16 +: 16] = v[15:0];
      end
      pending.push_back(e);
    endfunction

    function void check_matrix(logic [143:0] got);
      logic [143:0] e;
      if (pending.size() == 0) begin
        $error("unexpected matrix word %h", got);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 9; i++)
        if (got[i*16 +: 16] !== e[i*16 +: 16]) begin
          $error("out_r%0dc%0d expected %0d actual %0d", i / 3, i % 3,
                 $signed(e[i*16 +: 16]), $signed(got[i*16 +: 16]));
          errors++;
        end
    endfunction
  endclass

  logic clk_i = 0, rst_ni = 0;
  logic cfg_we_i = 0;
  logic [1:0] cfg_wdata_i = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [47:0] s_axis_tdata = 0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [143:0] m_axis_tdata;
  matrix_board board = new();
  int hold_off = 0;
  bit directed_done = 0;
  bit long_done = 0;

  always #4 clk_i = ~clk_i;

  euler_angles_to_rotation_matrix i_dut (.*);

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) board.check_matrix(m_axis_tdata);
    if (s_axis_tvalid && s_axis_tready) board.note_angles(s_axis_tdata);
  end

  // receiver stall pattern, with at least one long hold-off
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_axis_tready <= 0;
    end else if (directed_done && (!long_done || $urandom_range(0, 999) == 0)) begin
      hold_off <= 200;
      long_done <= 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 1) == 0);
    end
  end

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'(($urandom_range(0, 1) ? 1 : -1) * $urandom_range(12860, 12876));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_word(logic [47:0] w);
    s_axis_tdata <= w;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic pause_sender();
    s_axis_tvalid <= 0;
    repeat ($urandom_range(1, 6)) @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_conv(eatrm_pkg::conv_e c);
    cfg_wdata_i <= c;
    cfg_we_i <= 1;
    @(posedge clk_i);
    cfg_we_i <= 0;
    board.conv = c;
  endtask

  initial begin
    eatrm_pkg::conv_e modes[4];
    logic [15:0] edges[8];
    int burst;
    modes = '{eatrm_pkg::CONV_XYZ, eatrm_pkg::CONV_ZYZ, eatrm_pkg::CONV_ZYX,
              eatrm_pkg::CONV_RSV};
    edges = '{16'h0000, 16'h7fff, 16'h8000, 16'h3244, 16'hcdbc, 16'h6488, 16'h9b78, 16'h1922};
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    for (int m = 0; m < 4; m++) begin
      set_conv(modes[m]);
      for (int i = 0; i < 6; i++)
        send_word({edges[(i + 5) % 8], edges[(i + 2) % 8], edges[i]});
      drain();
    end
    directed_done = 1;
    for (int ph = 0; ph < 8; ph++) begin
      set_conv(modes[ph % 4]);
      for (int n = 0; n < 215; n += burst) begin
        burst = $urandom_range(1, 40);
        for (int k = 0; k < burst; k++)
          send_word({pick_angle(), pick_angle(), pick_angle()});
        if ($urandom_range(0, 2) == 0) pause_sender();
      end
      drain();
    end
    if (board.errors == 0 && board.pending.size() == 0)
      $display("euler_angles_to_rotation_matrix regression: pass");
    else
      $display("euler_angles_to_rotation_matrix regression: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("euler_angles_to_rotation_matrix regression: fail");
    $finish;
  end
endmodule
